### design/ltl_pkg.sv
`default_nettype none

package ltl_pkg;

  localparam int PADDR_W = 5;

  localparam logic [2:0] REG_STEP_LENGTH = 3'd0;
  localparam logic [2:0] REG_TURN_COS    = 3'd1;
  localparam logic [2:0] REG_TURN_SIN    = 3'd2;
  localparam logic [2:0] REG_ORIGIN_X    = 3'd3;
  localparam logic [2:0] REG_ORIGIN_Z    = 3'd4;

  localparam logic [15:0]        STEP_LENGTH_RST = 16'd2304;
  localparam logic signed [15:0] TURN_COS_RST    = 16'sd11585;
  localparam logic signed [15:0] TURN_SIN_RST    = 16'sd11585;
  localparam logic signed [15:0] ONE_Q14         = 16'sd16384;

  localparam logic [7:0] SYM_MOVE  = 8'h46;
  localparam logic [7:0] SYM_LEFT  = 8'h2B;
  localparam logic [7:0] SYM_RIGHT = 8'h2D;
  localparam logic [7:0] SYM_PUSH  = 8'h5B;
  localparam logic [7:0] SYM_POP   = 8'h5D;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MOVE,
    OP_TURN_L,
    OP_TURN_R,
    OP_PUSH,
    OP_POP
  } op_e;

  typedef enum logic [1:0] {
    KIND_SEGMENT   = 2'd0,
    KIND_OVERFLOW  = 2'd1,
    KIND_UNDERFLOW = 2'd2
  } kind_e;

  typedef struct packed {
    op_e  op;
    logic first;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        step_length;
    logic signed [15:0] turn_cos;
    logic signed [15:0] turn_sin;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_z;
  } cfg_t;

endpackage

`default_nettype wire

### design/ltl_in_if.sv
`default_nettype none

interface ltl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       first;

  modport source (output valid, output symbol, output first, input ready);
  modport sink (input valid, input symbol, input first, output ready);
endinterface

`default_nettype wire

### design/ltl_out_if.sv
`default_nettype none

interface ltl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [23:0] seg_x;
  logic signed [23:0] seg_z;
  logic signed [15:0] seg_sin;
  logic signed [15:0] seg_cos;
  logic signed [23:0] end_x;
  logic signed [23:0] end_z;

  modport source (
    output valid, output kind, output seg_x, output seg_z, output seg_sin,
    output seg_cos, output end_x, output end_z, input ready
  );
  modport sink (
    input valid, input kind, input seg_x, input seg_z, input seg_sin,
    input seg_cos, input end_x, input end_z, output ready
  );
endinterface

`default_nettype wire

### design/lsystem_turtle_interpreter_top.sv
// Turtle interpreter for an expanded L-system string, one ASCII symbol per item.
// F emits the current pose and the segment end point and moves the turtle, + and -
// rotate the heading, [ and ] push and pop the pose, and other symbols are ignored;
// the first flag returns the turtle to the origin registers with an empty stack.
// The block sustains one item per cycle with either side stalling on its own: the
// front decodes symbols into a two-entry queue and the back updates the pose from
// each item, its timing bounded by the feedback loop from the heading registers
// through the rotation multipliers. An accepted item is held in a queue entry, and
// its result is held in the output register until it is taken. The pose stack
// is a memory of STACK_DEPTH entries whose next top entry is read ahead into a
// register; it needs no clearing after reset.
`default_nettype none

module lsystem_turtle_interpreter_top #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ltl_in_if.sink                      in_i,
  ltl_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ltl_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ltl_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;
  logic       fe_valid, fe_ready, be_valid, be_ready;
  cmd_t       fe_cmd, be_cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_length <= STEP_LENGTH_RST;
      cfg_q.turn_cos    <= TURN_COS_RST;
      cfg_q.turn_sin    <= TURN_SIN_RST;
      cfg_q.origin_x    <= '0;
      cfg_q.origin_z    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STEP_LENGTH: cfg_q.step_length <= pwdata[15:0];
        REG_TURN_COS:    cfg_q.turn_cos    <= pwdata[15:0];
        REG_TURN_SIN:    cfg_q.turn_sin    <= pwdata[15:0];
        REG_ORIGIN_X:    cfg_q.origin_x    <= pwdata[23:0];
        REG_ORIGIN_Z:    cfg_q.origin_z    <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STEP_LENGTH: prdata = {16'd0, cfg_q.step_length};
      REG_TURN_COS:    prdata = {16'd0, cfg_q.turn_cos};
      REG_TURN_SIN:    prdata = {16'd0, cfg_q.turn_sin};
      REG_ORIGIN_X:    prdata = {8'd0, cfg_q.origin_x};
      REG_ORIGIN_Z:    prdata = {8'd0, cfg_q.origin_z};
      default:         prdata = '0;
    endcase
  end

  ltl_front u_front (
    .in_i        (in_i),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  ltl_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_cmd_i   (fe_cmd),
    .rd_valid_o (be_valid),
    .rd_ready_i (be_ready),
    .rd_cmd_o   (be_cmd)
  );

  ltl_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (be_valid),
    .cmd_ready_o (be_ready),
    .cmd_i       (be_cmd),
    .res_o       (out_o)
  );

endmodule

`default_nettype wire

### design/ltl_front.sv
`default_nettype none

module ltl_front (
  ltl_in_if.sink         in_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output ltl_pkg::cmd_t  cmd_o
);
  import ltl_pkg::*;

  op_e  op;
  logic keep;

  always_comb begin
    unique case (in_i.symbol)
      SYM_MOVE:  op = OP_MOVE;
      SYM_LEFT:  op = OP_TURN_L;
      SYM_RIGHT: op = OP_TURN_R;
      SYM_PUSH:  op = OP_PUSH;
      SYM_POP:   op = OP_POP;
      default:   op = OP_NOP;
    endcase
  end

  // Ignored symbols only matter when they carry the first flag.
  assign keep        = (op != OP_NOP) || in_i.first;
  assign cmd_valid_o = in_i.valid && keep;
  assign in_i.ready  = cmd_ready_i;
  assign cmd_o.op    = op;
  assign cmd_o.first = in_i.first;

endmodule

`default_nettype wire

### design/ltl_fifo.sv
`default_nettype none

module ltl_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  ltl_pkg::cmd_t wr_cmd_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output ltl_pkg::cmd_t rd_cmd_o
);
  import ltl_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_cmd_o   = entry_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= wr_cmd_i;
  end

endmodule

`default_nettype wire

### design/ltl_back.sv
`default_nettype none

module ltl_back #(
  parameter int STACK_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ltl_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  ltl_pkg::cmd_t cmd_i,
  ltl_out_if.source     res_o
);
  import ltl_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] z;
    logic signed [15:0] s;
    logic signed [15:0] c;
  } pose_t;

  function automatic logic signed [33:0] rnd14(input logic signed [33:0] v);
    rnd14 = (v + 34'sd8192) >>> 14;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
    if (v > 34'sd8388607) begin
      sat24 = 24'sh7FFFFF;
    end else if (v < -34'sd8388608) begin
      sat24 = 24'sh800000;
    end else begin
      sat24 = v[23:0];
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    if (v > 34'sd32767) begin
      sat16 = 16'sh7FFF;
    end else if (v < -34'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  pose_t              stk_mem [STACK_DEPTH];
  pose_t              cur_q, eff, nxt, rd_q;
  logic [CW-1:0]      cnt_q, ecnt, cnt_d, cnt_n, rd_cnt;
  logic [AW-1:0]      raddr, waddr;
  logic               we, fire, may_res, give_res, full, empty;
  logic signed [16:0] step_s, tc_s, tsx, ts_s, opd_a, opd_b;
  logic signed [32:0] prod_a, prod_b, prod_c, prod_d;
  logic signed [23:0] nx, nz;
  logic signed [15:0] ns, nc;

  logic               out_valid_q;
  kind_e              kind_q, kind_d;
  pose_t              seg_q, seg_d;
  logic signed [23:0] end_x_q, end_z_q, end_x_d, end_z_d;

  always_comb begin
    if (cmd_i.first) begin
      eff.x = cfg_i.origin_x;
      eff.z = cfg_i.origin_z;
      eff.s = '0;
      eff.c = ONE_Q14;
      ecnt  = '0;
    end else begin
      eff  = cur_q;
      ecnt = cnt_q;
    end
  end

  assign full  = (ecnt == CNT_FULL);
  assign empty = (ecnt == '0);

  // Four shared multipliers: a move uses the first two, a turn all four.
  assign step_s = $signed({1'b0, cfg_i.step_length});
  assign tc_s   = 17'(cfg_i.turn_cos);
  assign tsx    = 17'(cfg_i.turn_sin);
  assign ts_s   = (cmd_i.op == OP_TURN_R) ? -tsx : tsx;
  assign opd_a  = (cmd_i.op == OP_MOVE) ? step_s : tc_s;
  assign opd_b  = (cmd_i.op == OP_MOVE) ? step_s : ts_s;
  assign prod_a = 33'(eff.s) * 33'(opd_a);
  assign prod_b = 33'(eff.c) * 33'(opd_b);
  assign prod_c = 33'(eff.c) * 33'(tc_s);
  assign prod_d = 33'(eff.s) * 33'(ts_s);

  assign nx = sat24(34'(eff.x) + rnd14(34'(prod_a)));
  assign nz = sat24(34'(eff.z) + rnd14(34'(prod_b)));
  assign ns = sat16(rnd14(34'(prod_a) + 34'(prod_b)));
  assign nc = sat16(rnd14(34'(prod_c) - 34'(prod_d)));

  always_comb begin
    nxt      = eff;
    cnt_d    = ecnt;
    we       = 1'b0;
    may_res  = 1'b0;
    give_res = 1'b0;
    kind_d   = KIND_SEGMENT;
    seg_d    = '0;
    end_x_d  = '0;
    end_z_d  = '0;
    unique case (cmd_i.op)
      OP_MOVE: begin
        may_res  = 1'b1;
        give_res = 1'b1;
        seg_d    = eff;
        end_x_d  = nx;
        end_z_d  = nz;
        nxt.x    = nx;
        nxt.z    = nz;
      end
      OP_TURN_L, OP_TURN_R: begin
        nxt.s = ns;
        nxt.c = nc;
      end
      OP_PUSH: begin
        may_res = 1'b1;
        if (full) begin
          give_res = 1'b1;
          kind_d   = KIND_OVERFLOW;
        end else begin
          we    = 1'b1;
          cnt_d = ecnt + CW'(1);
        end
      end
      OP_POP: begin
        may_res = 1'b1;
        if (empty) begin
          give_res = 1'b1;
          kind_d   = KIND_UNDERFLOW;
        end else begin
          nxt   = rd_q;
          cnt_d = ecnt - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd_ready_o = !may_res || !out_valid_q || res_o.ready;
  assign fire        = cmd_valid_i && cmd_ready_o;

  // The top entry of the stack after the update is read ahead into rd_q.
  assign cnt_n  = fire ? cnt_d : cnt_q;
  assign rd_cnt = cnt_n - CW'(1);
  assign raddr  = rd_cnt[AW-1:0];
  assign waddr  = ecnt[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (fire && we) stk_mem[waddr] <= eff;
    if (fire && we && (waddr == raddr)) begin
      rd_q <= eff;
    end else begin
      rd_q <= stk_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q.x     <= '0;
      cur_q.z     <= '0;
      cur_q.s     <= '0;
      cur_q.c     <= ONE_Q14;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        cur_q <= nxt;
        cnt_q <= cnt_d;
      end
      if (fire && give_res) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && give_res) begin
      kind_q  <= kind_d;
      seg_q   <= seg_d;
      end_x_q <= end_x_d;
      end_z_q <= end_z_d;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.kind    = kind_q;
  assign res_o.seg_x   = seg_q.x;
  assign res_o.seg_z   = seg_q.z;
  assign res_o.seg_sin = seg_q.s;
  assign res_o.seg_cos = seg_q.c;
  assign res_o.end_x   = end_x_q;
  assign res_o.end_z   = end_z_q;

endmodule

`default_nettype wire
